// ===== design/bmc_pkg.sv =====
// Package for the battery monitor chain model: word types, command codes,
// chain constants and the byte-wise CRC-15 step. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package bmc_pkg;

   localparam int CHAIN_LENGTH_DEFAULT = 4;
   localparam int BYTES_PER_CHIP       = 6;
   localparam int CELLS_PER_CHIP       = 12;
   localparam int SLOTS_PER_CHIP       = 8;
   localparam int WRITE_DATA_START     = 4;

   localparam logic [15:0] CHECK_POLY     = 16'h4599;
   localparam logic [15:0] CHECK_SEED     = 16'd16;
   localparam logic [15:0] CHECK_TOP      = 16'h4000;
   localparam logic [15:0] CMD_CLEAR_MASK = 16'h0180;
   localparam logic [7:0]  WPOS_MAX       = 8'd255;

   // command codes
   localparam logic [15:0] CMD_WRCFG = 16'h0001;
   localparam logic [15:0] CMD_RDCFG = 16'h0002;
   localparam logic [15:0] CMD_RDCVA = 16'h0004;
   localparam logic [15:0] CMD_RDCVB = 16'h0006;
   localparam logic [15:0] CMD_RDCVC = 16'h0008;
   localparam logic [15:0] CMD_RDCVD = 16'h000A;

   typedef enum logic [1:0] {
      MODE_WRITE = 2'd0,
      MODE_READ  = 2'd1,
      MODE_LOAD  = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      RD_ZERO   = 2'd0,
      RD_CONFIG = 2'd1,
      RD_CELL   = 2'd2
   } rd_kind_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic        frame_start;
      logic [7:0]  data_byte;
      logic [3:0]  chip_select_index;
      logic [3:0]  cell_number;
      logic [15:0] cell_value;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       packet_last;
   } rsp_type;

   // read item between memory address and memory data
   typedef struct packed {
      rd_kind_type kind;
      logic [2:0]  slot;
      logic        last;
      logic [3:0]  cell_idx;
      logic        hit;
   } rd_stage_type;

   // one byte step of the CRC-15
   function automatic logic [15:0] crc15_byte(input logic [15:0] acc,
                                              input logic [7:0]  data);
      logic [15:0] rem;
      rem = {1'b0, acc[14:7] ^ data, 7'b0};
      for (int i = 0; i < 8; i++) begin
         if ((rem & CHECK_TOP) != 16'd0) begin
            rem = (rem << 1) ^ CHECK_POLY;
         end else begin
            rem = rem << 1;
         end
      end
      return (acc << 8) ^ rem;
   endfunction

endpackage

`default_nettype wire

// ===== design/bmc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module bmc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 24
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  wire logic [WIDTH-1:0]           wr_data,
   input  wire logic                       rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic      [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/battery_monitor_chain_spi_model.sv =====
// Battery monitor chain model: top level. Uses bmc_pkg for types and the
// CRC step, and bmc_ram for the configuration and cell voltage memories.
//
// Usage:
//   req channel (req_valid / req_stall / req_word) takes one word per item:
//   a host write byte, a read byte request or a cell voltage load.
//   rsp channel (rsp_valid / rsp_stall / rsp_word) returns one word for each
//   read request, in order, and nothing for the other modes.
//   Path: a read's memory address is issued when it is accepted; memory data
//   and byte/CRC select follow at the memory output, then the output register.
//   Throughput: one item per cycle while req_stall is low, any mix of modes;
//   the single read port of each memory and the one-byte CRC step set that figure.
//   Reset (synchronous, active high) clears the command, both positions and
//   the per-entry valid bits of both memories, and seeds the check accumulator;
//   an entry not yet written reads as its reset value, so no clearing pass.
//   When the receiver stalls, the output word holds; one more read may sit
//   at the memory output, and req_stall rises only while that read cannot
//   move into the output register.
`timescale 1ns / 1ps
`default_nettype none

module battery_monitor_chain_spi_model #(
   parameter int CHAIN_LENGTH = bmc_pkg::CHAIN_LENGTH_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire bmc_pkg::req_type req_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output bmc_pkg::rsp_type      rsp_word
);

   localparam int CFG_DEPTH    = CHAIN_LENGTH * bmc_pkg::BYTES_PER_CHIP;
   localparam int CELL_DEPTH   = CHAIN_LENGTH * bmc_pkg::CELLS_PER_CHIP;
   localparam int CFG_AW       = $clog2(CFG_DEPTH);
   localparam int CELL_AW      = $clog2(CELL_DEPTH);
   localparam int PACKET_BYTES = CHAIN_LENGTH * bmc_pkg::SLOTS_PER_CHIP;
   localparam int RPOS_W       = $clog2(PACKET_BYTES);

   // architectural registers
   logic [15:0]       cmd_ff, cmd_in;
   logic [7:0]        wpos_ff, wpos_in;
   logic [RPOS_W-1:0] rpos_ff, rpos_in;
   logic [15:0]       acc_ff, acc_in;
   logic [CFG_DEPTH-1:0]  cfg_valid_ff, cfg_valid_in;
   logic [CELL_DEPTH-1:0] cell_valid_ff, cell_valid_in;

   // pipeline registers
   logic                  s1_valid_ff, s1_valid_in;
   bmc_pkg::rd_stage_type s1_ff, s1_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   bmc_pkg::rsp_type      rsp_word_ff, rsp_word_in;

   // handshake
   logic out_free;
   logic s1_go;
   logic accept;
   logic rd_issue;

   // memory ports
   logic               cfg_wr_en;
   logic [CFG_AW-1:0]  cfg_wr_addr;
   logic               cfg_rd_en;
   logic [CFG_AW-1:0]  cfg_rd_addr;
   logic [7:0]         cfg_rd_data;
   logic               cell_wr_en;
   logic [CELL_AW-1:0] cell_wr_addr;
   logic               cell_rd_en;
   logic [CELL_AW-1:0] cell_rd_addr;
   logic [15:0]        cell_rd_data;

   // stage-0 helpers
   logic [7:0]  wpos_cur;
   logic [7:0]  wq;
   logic [4:0]  wgrp;
   logic [2:0]  wslot;
   logic [2:0]  rslot;
   logic [1:0]  rgroup;
   logic [3:0]  rcell;
   logic        rlast;

   // stage-1 helpers
   logic [15:0] cell_word;
   logic [7:0]  data_val;
   logic [7:0]  out_val;
   logic [15:0] pec;

   // Move the held read into the output register whenever it is empty or
   // being taken; hold the input only while the held read cannot move.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;
   assign rd_issue  = accept && (req_word.mode == bmc_pkg::MODE_READ);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // Stage 0: decode the item, update command and positions, issue memory
   // writes for config bytes and cell loads, issue memory reads for reads.
   always_comb begin
      cmd_in        = cmd_ff;
      wpos_in       = wpos_ff;
      rpos_in       = rpos_ff;
      cfg_valid_in  = cfg_valid_ff;
      cell_valid_in = cell_valid_ff;
      cfg_wr_en     = 1'b0;
      cell_wr_en    = 1'b0;
      cfg_rd_en     = 1'b0;
      cell_rd_en    = 1'b0;

      wpos_cur = (req_word.frame_start) ? 8'd0 : wpos_ff;
      wq       = wpos_cur - 8'(bmc_pkg::WRITE_DATA_START);
      wgrp     = wq[7:3];
      wslot    = wq[2:0];
      cfg_wr_addr = CFG_AW'((CHAIN_LENGTH - 1 - int'(wgrp)) * bmc_pkg::BYTES_PER_CHIP
                            + int'(wslot));
      cell_wr_addr = CELL_AW'(int'(req_word.chip_select_index) * bmc_pkg::CELLS_PER_CHIP
                              + int'(req_word.cell_number));

      rslot  = rpos_ff[2:0];
      rgroup = 2'(cmd_ff[3:1] - 3'd2);
      rcell  = 4'(int'(rgroup) * 3 + int'(rslot[2:1]));
      rlast  = (rpos_ff == RPOS_W'(PACKET_BYTES - 1));
      cfg_rd_addr  = CFG_AW'(int'(rpos_ff >> 3) * bmc_pkg::BYTES_PER_CHIP + int'(rslot));
      cell_rd_addr = CELL_AW'(int'(rpos_ff >> 3) * bmc_pkg::CELLS_PER_CHIP + int'(rcell));

      s1_in.slot     = rslot;
      s1_in.last     = rlast;
      s1_in.cell_idx = rcell;
      s1_in.hit      = 1'b0;
      s1_in.kind     = bmc_pkg::RD_ZERO;
      unique case (cmd_ff) inside
         bmc_pkg::CMD_RDCFG: begin
            s1_in.kind = bmc_pkg::RD_CONFIG;
            s1_in.hit  = cfg_valid_ff[cfg_rd_addr];
         end
         bmc_pkg::CMD_RDCVA, bmc_pkg::CMD_RDCVB,
         bmc_pkg::CMD_RDCVC, bmc_pkg::CMD_RDCVD: begin
            s1_in.kind = bmc_pkg::RD_CELL;
            s1_in.hit  = cell_valid_ff[cell_rd_addr];
         end
         default: begin
            s1_in.kind = bmc_pkg::RD_ZERO;
         end
      endcase

      if (accept) begin
         unique case (bmc_pkg::mode_type'(req_word.mode))
            bmc_pkg::MODE_WRITE: begin
               if (req_word.frame_start) begin
                  rpos_in = '0;
               end
               if (wpos_cur == 8'd0) begin
                  cmd_in = {req_word.data_byte, 8'd0} & ~bmc_pkg::CMD_CLEAR_MASK;
               end else if (wpos_cur == 8'd1) begin
                  cmd_in = {cmd_ff[15:8], req_word.data_byte} & ~bmc_pkg::CMD_CLEAR_MASK;
               end else if (wpos_cur >= 8'(bmc_pkg::WRITE_DATA_START)
                            && cmd_ff == bmc_pkg::CMD_WRCFG
                            && int'(wslot) < bmc_pkg::BYTES_PER_CHIP
                            && int'(wgrp) < CHAIN_LENGTH) begin
                  cfg_wr_en                 = 1'b1;
                  cfg_valid_in[cfg_wr_addr] = 1'b1;
               end
               if (wpos_cur != bmc_pkg::WPOS_MAX) begin
                  wpos_in = wpos_cur + 8'd1;
               end else begin
                  wpos_in = wpos_cur;
               end
            end
            bmc_pkg::MODE_READ: begin
               cfg_rd_en  = (s1_in.kind == bmc_pkg::RD_CONFIG);
               cell_rd_en = (s1_in.kind == bmc_pkg::RD_CELL);
               rpos_in    = rlast ? '0 : rpos_ff + RPOS_W'(1);
            end
            bmc_pkg::MODE_LOAD: begin
               if (int'(req_word.chip_select_index) < CHAIN_LENGTH
                   && int'(req_word.cell_number) < bmc_pkg::CELLS_PER_CHIP) begin
                  cell_wr_en                  = 1'b1;
                  cell_valid_in[cell_wr_addr] = 1'b1;
               end
            end
            default: begin
               // mode three: drop
            end
         endcase
      end
   end

   // Stage 1: pick the byte from memory data or the check word, advance CRC.
   always_comb begin
      cell_word = s1_ff.hit ? cell_rd_data : 16'(s1_ff.cell_idx) + 16'd1;
      case (s1_ff.kind)
         bmc_pkg::RD_CONFIG: data_val = s1_ff.hit ? cfg_rd_data : 8'd0;
         bmc_pkg::RD_CELL:   data_val = s1_ff.slot[0] ? cell_word[15:8] : cell_word[7:0];
         default:            data_val = 8'd0;
      endcase
      pec = acc_ff << 1;

      if (int'(s1_ff.slot) < bmc_pkg::BYTES_PER_CHIP) begin
         out_val = data_val;
      end else if (s1_ff.kind == bmc_pkg::RD_ZERO) begin
         out_val = 8'd0;
      end else if (int'(s1_ff.slot) == bmc_pkg::BYTES_PER_CHIP) begin
         out_val = pec[15:8];
      end else begin
         out_val = pec[7:0];
      end

      // a frame start seeds the check after the read ahead of it
      acc_in = acc_ff;
      if (s1_go && int'(s1_ff.slot) < bmc_pkg::BYTES_PER_CHIP) begin
         acc_in = bmc_pkg::crc15_byte((s1_ff.slot == 3'd0) ? bmc_pkg::CHECK_SEED : acc_ff,
                                      data_val);
      end
      if (accept && req_word.mode == bmc_pkg::MODE_WRITE && req_word.frame_start) begin
         acc_in = bmc_pkg::CHECK_SEED;
      end

      s1_valid_in  = rd_issue || (s1_valid_ff && !s1_go);
      rsp_valid_in = s1_go || (rsp_valid_ff && rsp_stall);
      rsp_word_in  = rsp_word_ff;
      if (s1_go) begin
         rsp_word_in.read_byte   = out_val;
         rsp_word_in.packet_last = s1_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_ff        <= '0;
         wpos_ff       <= '0;
         rpos_ff       <= '0;
         acc_ff        <= bmc_pkg::CHECK_SEED;
         cfg_valid_ff  <= '0;
         cell_valid_ff <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cmd_ff        <= cmd_in;
         wpos_ff       <= wpos_in;
         rpos_ff       <= rpos_in;
         acc_ff        <= acc_in;
         cfg_valid_ff  <= cfg_valid_in;
         cell_valid_ff <= cell_valid_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // payload registers: no reset
   always_ff @(posedge clock) begin
      if (rd_issue) begin
         s1_ff <= s1_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   bmc_ram #(
      .WIDTH (8),
      .DEPTH (CFG_DEPTH)
   ) u_cfg_ram (
      .clock   (clock),
      .wr_en   (cfg_wr_en),
      .wr_addr (cfg_wr_addr),
      .wr_data (req_word.data_byte),
      .rd_en   (cfg_rd_en),
      .rd_addr (cfg_rd_addr),
      .rd_data (cfg_rd_data)
   );

   bmc_ram #(
      .WIDTH (16),
      .DEPTH (CELL_DEPTH)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (cell_wr_en),
      .wr_addr (cell_wr_addr),
      .wr_data (req_word.cell_value),
      .rd_en   (cell_rd_en),
      .rd_addr (cell_rd_addr),
      .rd_data (cell_rd_data)
   );

   // a read never lands on a held read that cannot move
   assert property (@(posedge clock) disable iff (reset)
      rd_issue |-> (!s1_valid_ff || s1_go))
      else $error("read issued over a held read");

   // every accepted read reaches the memory output stage
   assert property (@(posedge clock) disable iff (reset)
      rd_issue |=> s1_valid_ff)
      else $error("accepted read lost before memory output");

   // a frame start leaves the check seeded
   assert property (@(posedge clock) disable iff (reset)
      (accept && req_word.mode == bmc_pkg::MODE_WRITE && req_word.frame_start)
      |=> (acc_ff == bmc_pkg::CHECK_SEED))
      else $error("check not seeded after frame start");

   // a word that leaves the memory stage shows in the output register with its last flag
   assert property (@(posedge clock) disable iff (reset)
      s1_go |=> (rsp_valid_ff && rsp_word_ff.packet_last == $past(s1_ff.last)))
      else $error("read word lost on its way to the output");

endmodule

`default_nettype wire

// ===== tb/sv/battery_monitor_chain_spi_model_tb.sv =====
// Self-checking bench for the battery monitor chain model: directed table, then random frames.
// Needs bmc_pkg and the battery_monitor_chain_spi_model top level.
`timescale 1ns / 1ps

module battery_monitor_chain_spi_model_tb;
   import bmc_pkg::*;

   localparam int CHAIN        = CHAIN_LENGTH_DEFAULT;
   localparam int PACKET_BYTES = CHAIN * SLOTS_PER_CHIP;
   localparam int RANDOM_ITEMS = 1250;
   localparam int DRAIN_LIMIT  = 20000;
   localparam int DRAIN_TAIL   = 16;
   localparam int SHOW_LIMIT   = 10;

   // mode 3 has no name in the package; the block ignores it
   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_word = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_word;

   // typed-in reply carried alongside the request word (bench side only)
   logic    word_typed = 1'b0;
   rsp_type typed_rsp = '0;

   int sender_idle_pct = 0;
   int rsp_stall_pct   = 0;
   int errors          = 0;
   int sent            = 0;

   // predicted chain state
   logic [15:0] cmd_code;
   logic [7:0]  write_pos;
   logic [7:0]  read_pos;
   logic [7:0]  chip_cfg [CHAIN * BYTES_PER_CHIP];
   logic [15:0] cell_volts [CHAIN * CELLS_PER_CHIP];
   logic [15:0] pec_acc;

   rsp_type expected_bytes [$];

   typedef struct {
      req_type w;
      bit      typed;
      rsp_type reply;
   } dir_row_type;

   dir_row_type dir_table [$];

   battery_monitor_chain_spi_model #(.CHAIN_LENGTH(CHAIN)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------------------------------

   function automatic void chain_reset();
      cmd_code  = '0;
      write_pos = '0;
      read_pos  = '0;
      pec_acc   = CHECK_SEED;
      foreach (chip_cfg[i]) chip_cfg[i] = '0;
      // every chip powers up with cell j reading j + 1
      foreach (cell_volts[i]) cell_volts[i] = 16'((i % CELLS_PER_CHIP) + 1);
   endfunction

   // CRC-15 over one byte, MSB first
   function automatic logic [15:0] check_step(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] rem;
      rem = 16'(acc[14:7] ^ b) << 7;
      for (int i = 0; i < 8; i++) begin
         rem = rem[14] ? ((rem << 1) ^ CHECK_POLY) : (rem << 1);
      end
      return (acc << 8) ^ rem;
   endfunction

   // {served, byte} for data byte k of a chip under the current command
   function automatic logic [8:0] data_for(input int chip, input int k);
      int          grp;
      logic [15:0] v;
      case (cmd_code)
         CMD_RDCFG: return {1'b1, chip_cfg[chip * BYTES_PER_CHIP + k]};
         CMD_RDCVA: grp = 0;
         CMD_RDCVB: grp = 1;
         CMD_RDCVC: grp = 2;
         CMD_RDCVD: grp = 3;
         default:   return 9'd0;
      endcase
      v = cell_volts[chip * CELLS_PER_CHIP + grp * 3 + k / 2];
      // cells go out low byte first
      return {1'b1, (k % 2 == 1) ? v[15:8] : v[7:0]};
   endfunction

   // advance the chain by one word; returns 1 when it owes a reply
   function automatic bit spi_chain_respond(input req_type w, output rsp_type reply);
      int          pos;
      int          q;
      int          grp;
      int          off;
      int          r;
      int          chip;
      bit          last;
      logic [8:0]  served;
      logic [15:0] pec;
      logic [7:0]  val;
      reply = '0;
      case (w.mode)
         MODE_WRITE: begin
            if (w.frame_start) begin
               write_pos = '0;
               read_pos  = '0;
               pec_acc   = CHECK_SEED;
            end
            pos = int'(write_pos);
            if (pos == 0) begin
               cmd_code = {w.data_byte, 8'h00} & ~CMD_CLEAR_MASK;
            end else if (pos == 1) begin
               cmd_code = {cmd_code[15:8], w.data_byte} & ~CMD_CLEAR_MASK;
            end else if (pos >= WRITE_DATA_START && cmd_code == CMD_WRCFG) begin
               // group i lands on chip CHAIN-1-i; check bytes and extra groups drop
               q   = pos - WRITE_DATA_START;
               grp = q / SLOTS_PER_CHIP;
               off = q % SLOTS_PER_CHIP;
               if (off < BYTES_PER_CHIP && grp < CHAIN) begin
                  chip_cfg[(CHAIN - 1 - grp) * BYTES_PER_CHIP + off] = w.data_byte;
               end
            end
            if (write_pos < WPOS_MAX) write_pos = write_pos + 8'd1;
            return 1'b0;
         end
         MODE_READ: begin
            r    = int'(read_pos);
            chip = r / SLOTS_PER_CHIP;
            off  = r % SLOTS_PER_CHIP;
            last = (r == PACKET_BYTES - 1);
            if (chip >= CHAIN) chip = 0;
            if (off < BYTES_PER_CHIP) begin
               served  = data_for(chip, off);
               val     = served[7:0];
               pec_acc = check_step((off == 0) ? CHECK_SEED : pec_acc, val);
            end else begin
               // check word is the accumulator doubled, high byte first
               pec    = pec_acc << 1;
               served = data_for(chip, 0);
               val    = (off == 6) ? pec[15:8] : pec[7:0];
            end
            if (!served[8]) val = '0;
            reply.read_byte   = val;
            reply.packet_last = last;
            read_pos = (r >= PACKET_BYTES - 1) ? 8'd0 : 8'(r + 1);
            return 1'b1;
         end
         MODE_LOAD: begin
            if (w.chip_select_index < CHAIN && w.cell_number < CELLS_PER_CHIP) begin
               cell_volts[w.chip_select_index * CELLS_PER_CHIP + w.cell_number] = w.cell_value;
            end
            return 1'b0;
         end
         default: return 1'b0;
      endcase
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Word builders: fields the mode does not use get random values so every bit toggles
   // ---------------------------------------------------------------------------------------------

   function automatic req_type write_word(input bit start, input logic [7:0] b);
      req_type w;
      w                   = '0;
      w.mode              = MODE_WRITE;
      w.frame_start       = start;
      w.data_byte         = b;
      w.chip_select_index = 4'($urandom);
      w.cell_number       = 4'($urandom);
      w.cell_value        = 16'($urandom);
      return w;
   endfunction

   function automatic req_type read_word();
      req_type w;
      w                   = '0;
      w.mode              = MODE_READ;
      w.frame_start       = 1'($urandom);
      w.data_byte         = 8'($urandom);
      w.chip_select_index = 4'($urandom);
      w.cell_number       = 4'($urandom);
      w.cell_value        = 16'($urandom);
      return w;
   endfunction

   function automatic req_type load_word(input logic [3:0] chip, input logic [3:0] cell_num,
                                         input logic [15:0] value);
      req_type w;
      w                   = '0;
      w.mode              = MODE_LOAD;
      w.frame_start       = 1'($urandom);
      w.data_byte         = 8'($urandom);
      w.chip_select_index = chip;
      w.cell_number       = cell_num;
      w.cell_value        = value;
      return w;
   endfunction

   function automatic dir_row_type dir_row(input req_type w, input bit typed,
                                           input logic [7:0] b, input logic l);
      dir_row_type row;
      row.w                 = w;
      row.typed             = typed;
      row.reply.read_byte   = b;
      row.reply.packet_last = l;
      return row;
   endfunction

   function automatic void report_fail(input string msg);
      errors++;
      if (errors <= SHOW_LIMIT) $display("mismatch: %s", msg);
   endfunction

   // ---------------------------------------------------------------------------------------------
   // Driver: change inputs at the falling edge, hold the word until it is taken
   // ---------------------------------------------------------------------------------------------

   task automatic send_word(input req_type w, input bit typed, input rsp_type reply);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid  <= 1'b1;
      req_word   <= w;
      word_typed <= typed;
      typed_rsp  <= reply;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
      // ignored words do not count toward the stimulus length
      if (w.mode != MODE_SPARE) sent++;
   endtask

   task automatic send_plain(input req_type w);
      send_word(w, 1'b0, '0);
   endtask

   // receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_stall_pct);
   end

   // ---------------------------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge
   // ---------------------------------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_type predicted;
      rsp_type oldest;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               report_fail($sformatf("unexpected reply %02h last %0b",
                                     rsp_word.read_byte, rsp_word.packet_last));
            end else begin
               oldest = expected_bytes.pop_front();
               if (rsp_word.read_byte !== oldest.read_byte)
                  report_fail($sformatf("read_byte expected %02h got %02h",
                                        oldest.read_byte, rsp_word.read_byte));
               if (rsp_word.packet_last !== oldest.packet_last)
                  report_fail($sformatf("packet_last expected %0b got %0b",
                                        oldest.packet_last, rsp_word.packet_last));
            end
         end
         if (req_valid && !req_stall) begin
            // typed rows still advance the predictor, but their reply is fixed
            if (spi_chain_respond(req_word, predicted))
               expected_bytes.push_back(word_typed ? typed_rsp : predicted);
         end
      end
   end

   // ---------------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------------

   initial begin
      req_type     spare;
      logic [15:0] cmd;
      logic [63:0] noise_bits;
      int          pick;
      int          n;
      int          waited;
      bit          drained;

      chain_reset();
      spare = '1;   // mode 3 with every field at its maximum

      // directed table; typed replies only where the value is obvious
      dir_table.push_back(dir_row(read_word(), 1, 8'h00, 0));            // idle command reads zero
      dir_table.push_back(dir_row(write_word(1, 8'h00), 0, 8'h00, 0));
      dir_table.push_back(dir_row(write_word(0, 8'h04), 0, 8'h00, 0));   // cell group A
      dir_table.push_back(dir_row(read_word(), 1, 8'h01, 0));            // cell 0 low
      dir_table.push_back(dir_row(read_word(), 1, 8'h00, 0));            // cell 0 high
      dir_table.push_back(dir_row(read_word(), 1, 8'h02, 0));            // cell 1 low
      dir_table.push_back(dir_row(load_word(4'd0, 4'd1, 16'hFFFF), 0, 8'h00, 0));
      dir_table.push_back(dir_row(read_word(), 1, 8'hFF, 0));            // load seen mid-packet
      dir_table.push_back(dir_row(load_word(4'd15, 4'd0, 16'hAAAA), 0, 8'h00, 0));
      dir_table.push_back(dir_row(load_word(4'd0, 4'd15, 16'h5555), 0, 8'h00, 0));
      dir_table.push_back(dir_row(spare, 0, 8'h00, 0));
      dir_table.push_back(dir_row(read_word(), 1, 8'h03, 0));            // cell 2 low
      dir_table.push_back(dir_row(read_word(), 1, 8'h00, 0));            // cell 2 high
      dir_table.push_back(dir_row(read_word(), 0, 8'h00, 0));            // check high
      dir_table.push_back(dir_row(read_word(), 0, 8'h00, 0));            // check low
      dir_table.push_back(dir_row(write_word(1, 8'h01), 0, 8'h00, 0));   // bits 7 and 8 set
      dir_table.push_back(dir_row(write_word(0, 8'h82), 0, 8'h00, 0));   // reads as config
      dir_table.push_back(dir_row(read_word(), 1, 8'h00, 0));
      dir_table.push_back(dir_row(write_word(1, 8'h00), 0, 8'h00, 0));
      dir_table.push_back(dir_row(write_word(0, 8'h01), 0, 8'h00, 0));   // write config
      dir_table.push_back(dir_row(write_word(0, 8'h00), 0, 8'h00, 0));   // command check, dropped
      dir_table.push_back(dir_row(write_word(0, 8'hFF), 0, 8'h00, 0));
      dir_table.push_back(dir_row(write_word(0, 8'hFF), 0, 8'h00, 0));   // last chip, byte 0
      dir_table.push_back(dir_row(write_word(1, 8'h00), 0, 8'h00, 0));
      dir_table.push_back(dir_row(write_word(0, 8'h0F), 0, 8'h00, 0));   // unknown command
      dir_table.push_back(dir_row(read_word(), 1, 8'h00, 0));

      // hold reset from time zero, release it on a falling edge
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (dir_table[i]) send_word(dir_table[i].w, dir_table[i].typed, dir_table[i].reply);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         // rotate through the idling phases
         case ((sent / 120) % 4)
            0: begin sender_idle_pct = 0;  rsp_stall_pct = 0;  end
            1: begin sender_idle_pct = 87; rsp_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  rsp_stall_pct = 87; end
            default: begin sender_idle_pct = 8; rsp_stall_pct = 8; end
         endcase
         pick = $urandom_range(99);
         if (pick < 70) begin
            // well-formed frame: command, check, then config data or a read burst with some loads
            case ($urandom_range(6))
               0: cmd = CMD_WRCFG;
               1: cmd = CMD_RDCFG;
               2: cmd = CMD_RDCVA;
               3: cmd = CMD_RDCVB;
               4: cmd = CMD_RDCVC;
               5: cmd = CMD_RDCVD;
               default: cmd = 16'($urandom);
            endcase
            if ($urandom_range(3) == 0) cmd = cmd | (CMD_CLEAR_MASK & 16'($urandom));
            send_plain(write_word(1'b1, cmd[15:8]));
            send_plain(write_word(1'b0, cmd[7:0]));
            send_plain(write_word(1'b0, 8'($urandom)));
            send_plain(write_word(1'b0, 8'($urandom)));
            if ((cmd & ~CMD_CLEAR_MASK) == CMD_WRCFG) begin
               // now and then run the frame far past the chain to saturate the position
               n = ($urandom_range(24) == 0) ? $urandom_range(240, 270)
                                             : $urandom_range(1, PACKET_BYTES + 2);
               repeat (n) send_plain(write_word(1'b0, 8'($urandom)));
            end else begin
               n = $urandom_range(1, PACKET_BYTES + 6);
               repeat (n) begin
                  if ($urandom_range(9) == 0)
                     send_plain(load_word(4'($urandom_range(CHAIN - 1)),
                                          4'($urandom_range(CELLS_PER_CHIP - 1)),
                                          16'($urandom)));
                  else
                     send_plain(read_word());
               end
            end
         end else if (pick < 85) begin
            // load burst, mostly in range
            repeat ($urandom_range(1, 6)) begin
               send_plain(load_word(
                  4'(($urandom_range(7) == 0) ? $urandom_range(15) : $urandom_range(CHAIN - 1)),
                  4'(($urandom_range(7) == 0) ? $urandom_range(15)
                                              : $urandom_range(CELLS_PER_CHIP - 1)),
                  16'($urandom)));
            end
         end else begin
            // noise: any mode, stray frame starts, writes with no frame start
            repeat ($urandom_range(1, 4)) begin
               noise_bits = {$urandom, $urandom};
               send_plain(noise_bits[$bits(req_type)-1:0]);
            end
         end
      end
      req_valid <= 1'b0;

      // drain the outstanding replies, then give the pipeline time to show strays
      waited = 0;
      while (expected_bytes.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (DRAIN_TAIL) @(posedge clock);
      drained = (expected_bytes.size() == 0);
      if (!drained) report_fail($sformatf("%0d replies never arrived", expected_bytes.size()));

      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // hard stop well past the slowest correct run
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
design/bmc_pkg.sv
design/bmc_ram.sv
design/battery_monitor_chain_spi_model.sv
tb/sv/battery_monitor_chain_spi_model_tb.sv
